// ----- hw/rtl/scba_pkg.sv -----
// Shared types and constants for the size-class block allocator.
// No dependencies; imported by the allocator top level.
`timescale 1ns / 1ps
`default_nettype none
package scba_pkg;

    localparam int ADDR_W  = 15;
    localparam int COUNT_W = 32;
    localparam int SIZE_W  = 16;
    localparam int STAT_W  = 2;
    localparam int OP_W    = 2;
    localparam int OUT_PAGES_W = 7;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [OP_W-1:0]    opcode_t;
    typedef logic [STAT_W-1:0]  status_t;

    localparam opcode_t OP_ALLOC  = 2'd0;
    localparam opcode_t OP_FREE   = 2'd1;
    localparam opcode_t OP_REDUCE = 2'd2;

    localparam status_t ST_OK         = 2'd0;
    localparam status_t ST_BAD_SIZE   = 2'd1;
    localparam status_t ST_POOL_EMPTY = 2'd2;

    localparam count_t COUNTDOWN_RESET = 32'd1048576;

    localparam int ADDR_SPACE = 32768;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 24;

endpackage : scba_pkg
`default_nettype wire

// ----- hw/rtl/scba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; used for the free-list heads and the block link store.
`timescale 1ns / 1ps
`default_nettype none
module scba_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule : scba_ram
`default_nettype wire

// ----- hw/rtl/size_class_block_allocator.sv -----
// Top level of the size-class block allocator: sequencer, class decode and page carving.
// Depends on scba_pkg and on scba_ram for the free-list heads and block links.
//
// Channel   Direction  Handshake          Contents
// s_        in         s_tvalid/s_tready  tuser: opcode; tdata: size, block address, amount
// m_        out        m_tvalid/m_tready  tuser: status; tdata: address, collect flag, pages
// cfg_      in         cfg_wen            countdown budget, loaded into the countdown
//
// A reduce, an unused opcode, a bad size or a free of address zero goes from class decode
// straight to the result; a free or an exhausted pool first reads the list head, and an
// allocate that succeeds then reads the head's link; a page carve writes a link per block.
// The next input can be accepted in the cycle after the result transaction completes.
// Reset clears the free lists and page count and loads the default budget.
// The block takes one transaction at a time and holds the result until m_tready.
`timescale 1ns / 1ps
`default_nettype none
module size_class_block_allocator #(
    parameter int NUM_CLASSES  = 16,
    parameter int PAGE_WORDS   = 512,
    parameter int HEADER_WORDS = 1,
    parameter int WORD_BYTES   = 8,
    parameter int NUM_PAGES    = 64
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Bits from 0: size_bytes[15:0], block_addr[30:16], amount[62:31], zero pad.
    input  wire logic [scba_pkg::S_TDATA_W-1:0]  s_tdata,
    // Bits from 0: opcode[1:0].
    input  wire logic [scba_pkg::OP_W-1:0]       s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Bits from 0: result_addr[14:0], collect_due[15], pages_in_use[22:16], zero pad.
    output logic      [scba_pkg::M_TDATA_W-1:0]  m_tdata,
    // Bits from 0: status[1:0].
    output logic      [scba_pkg::STAT_W-1:0]     m_tuser,
    input  wire logic                            cfg_wen,
    input  wire logic [scba_pkg::COUNT_W-1:0]    cfg_wdata
);

    import scba_pkg::*;

    localparam int FIT_PAGES  = ADDR_SPACE / PAGE_WORDS;
    localparam int POOL_LIMIT = (NUM_PAGES < FIT_PAGES) ? NUM_PAGES : FIT_PAGES;
    localparam int PAGES_W    = $clog2(POOL_LIMIT + 1);
    localparam int CLS_W      = $clog2(NUM_CLASSES);
    localparam int USABLE     = PAGE_WORDS - HEADER_WORDS;
    localparam int SPAN       = NUM_CLASSES * WORD_BYTES;
    localparam int NUM_W      = $clog2(SPAN);
    localparam int RECIP_SH   = 16;
    localparam int RECIP      = ((1 << RECIP_SH) + WORD_BYTES - 1) / WORD_BYTES;
    localparam int RECIP_W    = 17;
    localparam int PROD_W     = NUM_W + RECIP_W;
    localparam int PTR_W      = ADDR_W + 1;
    localparam int CMP_W      = 13;

    localparam logic [SIZE_W:0]      ROUND_ADD  = (SIZE_W+1)'(WORD_BYTES - 1);
    localparam logic [SIZE_W:0]      SPAN_LIM   = (SIZE_W+1)'(SPAN);
    localparam logic [RECIP_W-1:0]   RECIP_C    = RECIP_W'(RECIP);
    localparam logic [CMP_W-1:0]     USABLE_C   = CMP_W'(USABLE);
    localparam logic [PTR_W-1:0]     PAGE_C     = PTR_W'(PAGE_WORDS);
    localparam logic [PTR_W-1:0]     HEADER_C   = PTR_W'(HEADER_WORDS);
    localparam logic [PAGES_W-1:0]   LIMIT_C    = PAGES_W'(POOL_LIMIT);
    localparam count_t               PAGE_BYTES = COUNT_W'(PAGE_WORDS * WORD_BYTES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLASS = 3'd1;
    localparam logic [2:0] S_HREQ  = 3'd2;
    localparam logic [2:0] S_HDATA = 3'd3;
    localparam logic [2:0] S_CARVE = 3'd4;
    localparam logic [2:0] S_LREQ  = 3'd5;
    localparam logic [2:0] S_LDATA = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]             state_reg,     state_next;
    opcode_t                opcode_reg,    opcode_next;
    logic [SIZE_W-1:0]      size_reg,      size_next;
    addr_t                  baddr_reg,     baddr_next;
    count_t                 amount_reg,    amount_next;
    logic [CLS_W-1:0]       cls_reg,       cls_next;
    addr_t                  head_reg,      head_next;
    logic [PTR_W-1:0]       cur_reg,       cur_next;
    logic [PTR_W-1:0]       page_reg,      page_next;
    logic [PAGES_W-1:0]     pages_reg,     pages_next;
    count_t                 countdown_reg, countdown_next;
    addr_t                  res_reg,       res_next;
    status_t                status_reg,    status_next;
    logic [NUM_CLASSES-1:0] hvalid_reg,    hvalid_next;

    logic [SIZE_W:0]        rounded;
    logic [PROD_W-1:0]      prod;
    logic [CLS_W-1:0]       cls_calc;
    logic [CMP_W-1:0]       cls_wide;
    logic                   size_bad;
    logic [PTR_W-1:0]       blk_next;
    logic [PTR_W-1:0]       blk_after;
    logic [PTR_W-1:0]       page_end;
    logic                   carve_last;
    addr_t                  head_val;
    logic [PAGES_W+OUT_PAGES_W-1:0] pages_ext;

    logic                   hd_wr_en, hd_rd_en;
    logic [CLS_W-1:0]       hd_wr_addr;
    addr_t                  hd_wr_data, hd_rd_data;
    logic                   lk_wr_en, lk_rd_en;
    addr_t                  lk_wr_addr, lk_wr_data, lk_rd_data;

    scba_ram #(.WIDTH(ADDR_W), .DEPTH(NUM_CLASSES)) u_heads (
        .aclk    (aclk),
        .wr_en   (hd_wr_en),
        .wr_addr (hd_wr_addr),
        .wr_data (hd_wr_data),
        .rd_en   (hd_rd_en),
        .rd_addr (cls_reg),
        .rd_data (hd_rd_data)
    );

    scba_ram #(.WIDTH(ADDR_W), .DEPTH(ADDR_SPACE)) u_links (
        .aclk    (aclk),
        .wr_en   (lk_wr_en),
        .wr_addr (lk_wr_addr),
        .wr_data (lk_wr_data),
        .rd_en   (lk_rd_en),
        .rd_addr (head_reg),
        .rd_data (lk_rd_data)
    );

    function automatic count_t reduce_sat(input count_t cur, input count_t amt);
        return (cur >= amt) ? (cur - amt) : '0;
    endfunction

    assign rounded  = {1'b0, size_reg} + ROUND_ADD;
    assign prod     = PROD_W'(rounded[NUM_W-1:0]) * PROD_W'(RECIP_C);
    assign cls_calc = prod[RECIP_SH +: CLS_W];
    assign cls_wide = CMP_W'(cls_calc);
    assign size_bad = (size_reg == '0) || (rounded >= SPAN_LIM) || (cls_wide > USABLE_C);

    assign blk_next   = cur_reg + PTR_W'(cls_reg);
    assign blk_after  = blk_next + PTR_W'(cls_reg);
    assign page_end   = page_reg + PAGE_C;
    assign carve_last = (blk_after > page_end);
    assign head_val   = hvalid_reg[cls_reg] ? hd_rd_data : '0;

    always_comb begin
        state_next     = state_reg;
        opcode_next    = opcode_reg;
        size_next      = size_reg;
        baddr_next     = baddr_reg;
        amount_next    = amount_reg;
        cls_next       = cls_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        page_next      = page_reg;
        pages_next     = pages_reg;
        countdown_next = countdown_reg;
        res_next       = res_reg;
        status_next    = status_reg;
        hvalid_next    = hvalid_reg;
        hd_wr_en       = 1'b0;
        hd_wr_addr     = cls_reg;
        hd_wr_data     = '0;
        hd_rd_en       = 1'b0;
        lk_wr_en       = 1'b0;
        lk_wr_addr     = '0;
        lk_wr_data     = '0;
        lk_rd_en       = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    opcode_next = s_tuser;
                    size_next   = s_tdata[15:0];
                    baddr_next  = s_tdata[30:16];
                    amount_next = s_tdata[62:31];
                    res_next    = '0;
                    status_next = ST_OK;
                    state_next  = S_CLASS;
                end
            end
            S_CLASS: begin
                cls_next = cls_calc;
                if (opcode_reg == OP_REDUCE) begin
                    countdown_next = reduce_sat(countdown_reg, amount_reg);
                    state_next     = S_OUT;
                end else if (opcode_reg == OP_ALLOC || opcode_reg == OP_FREE) begin
                    if (size_bad) begin
                        status_next = ST_BAD_SIZE;
                        state_next  = S_OUT;
                    end else if (opcode_reg == OP_FREE && baddr_reg == '0) begin
                        state_next = S_OUT;
                    end else begin
                        state_next = S_HREQ;
                    end
                end else begin
                    state_next = S_OUT;
                end
            end
            S_HREQ: begin
                hd_rd_en   = 1'b1;
                state_next = S_HDATA;
            end
            S_HDATA: begin
                if (opcode_reg == OP_FREE) begin
                    lk_wr_en    = 1'b1;
                    lk_wr_addr  = baddr_reg;
                    lk_wr_data  = head_val;
                    hd_wr_en    = 1'b1;
                    hd_wr_data  = baddr_reg;
                    hvalid_next[cls_reg] = 1'b1;
                    state_next  = S_OUT;
                end else if (head_val != '0) begin
                    head_next  = head_val;
                    state_next = S_LREQ;
                end else if (pages_reg >= LIMIT_C) begin
                    status_next = ST_POOL_EMPTY;
                    state_next  = S_OUT;
                end else begin
                    cur_next   = page_reg + HEADER_C;
                    state_next = S_CARVE;
                end
            end
            S_CARVE: begin
                lk_wr_en   = 1'b1;
                lk_wr_addr = cur_reg[ADDR_W-1:0];
                lk_wr_data = carve_last ? '0 : blk_next[ADDR_W-1:0];
                cur_next   = blk_next;
                if (carve_last) begin
                    head_next      = ADDR_W'(page_reg + HEADER_C);
                    page_next      = page_end;
                    pages_next     = pages_reg + PAGES_W'(1);
                    countdown_next = reduce_sat(countdown_reg, PAGE_BYTES);
                    state_next     = S_LREQ;
                end
            end
            S_LREQ: begin
                lk_rd_en   = 1'b1;
                state_next = S_LDATA;
            end
            S_LDATA: begin
                hd_wr_en    = 1'b1;
                hd_wr_data  = lk_rd_data;
                hvalid_next[cls_reg] = 1'b1;
                res_next    = head_reg;
                state_next  = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wen) begin
            countdown_next = cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            page_reg      <= '0;
            pages_reg     <= '0;
            countdown_reg <= COUNTDOWN_RESET;
            hvalid_reg    <= '0;
        end else begin
            state_reg     <= state_next;
            page_reg      <= page_next;
            pages_reg     <= pages_next;
            countdown_reg <= countdown_next;
            hvalid_reg    <= hvalid_next;
        end
        opcode_reg <= opcode_next;
        size_reg   <= size_next;
        baddr_reg  <= baddr_next;
        amount_reg <= amount_next;
        cls_reg    <= cls_next;
        head_reg   <= head_next;
        cur_reg    <= cur_next;
        res_reg    <= res_next;
        status_reg <= status_next;
    end

    assign pages_ext = {{OUT_PAGES_W{1'b0}}, pages_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = status_reg;
    assign m_tdata  = {1'b0, pages_ext[OUT_PAGES_W-1:0], (countdown_reg == '0), res_reg};

endmodule : size_class_block_allocator
`default_nettype wire

// ----- test/tb_size_class_block_allocator.sv -----
// Self-checking testbench for the size-class block allocator: directed and random
// allocate, free and countdown requests checked against a behavioral allocator model.
// Depends on scba_pkg and the size_class_block_allocator RTL.
`timescale 1ns / 1ps
module tb_size_class_block_allocator;
    import scba_pkg::*;

    localparam int NUM_CLASSES  = 16;
    localparam int PAGE_WORDS   = 512;
    localparam int HEADER_WORDS = 1;
    localparam int WORD_BYTES   = 8;
    localparam int NUM_PAGES    = 64;
    localparam int POOL_PAGES   = (NUM_PAGES < ADDR_SPACE / PAGE_WORDS) ?
                                  NUM_PAGES : ADDR_SPACE / PAGE_WORDS;
    localparam int TOP_CLASS    = NUM_CLASSES - 1;
    localparam int MAX_SIZE     = TOP_CLASS * WORD_BYTES;
    localparam int MAX_GAP      = 18;
    localparam int STALL_LIMIT  = 4000;
    localparam opcode_t OP_UNUSED = 2'd3;

    typedef struct packed {
        opcode_t     op;
        logic [15:0] size;
        addr_t       addr;
        count_t      amount;
    } request_t;

    typedef struct packed {
        addr_t      addr;
        status_t    status;
        logic       due;
        logic [6:0] pages;
    } outcome_t;

    typedef struct {
        addr_t       addr;
        int unsigned cls;
    } live_block_t;

    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [OP_W-1:0]       s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [STAT_W-1:0]     m_tuser;
    logic                  cfg_wen   = 1'b0;
    logic [COUNT_W-1:0]    cfg_wdata = '0;

    addr_t       free_heads [NUM_CLASSES] = '{default: '0};
    addr_t       block_link [ADDR_SPACE];
    int unsigned pages_out  = 0;
    count_t      countdown  = COUNTDOWN_RESET;

    request_t    requests_to_send[$];
    outcome_t    outcomes_due[$];
    live_block_t live_blocks[$];
    request_t    in_flight;
    int unsigned send_gap    = 0;
    int unsigned hold_cycles = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches  = 0;
    bit          no_idle     = 1'b0;

    size_class_block_allocator #(
        .NUM_CLASSES (NUM_CLASSES),
        .PAGE_WORDS  (PAGE_WORDS),
        .HEADER_WORDS(HEADER_WORDS),
        .WORD_BYTES  (WORD_BYTES),
        .NUM_PAGES   (NUM_PAGES)
    ) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned class_of_bytes(input logic [15:0] sz);
        int unsigned c;
        c = (32'(sz) + WORD_BYTES - 1) / WORD_BYTES;
        if (c == 0 || c >= NUM_CLASSES || c > PAGE_WORDS - HEADER_WORDS) return 0;
        return c;
    endfunction

    function automatic int unsigned draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    task automatic drain_countdown(input logic [32:0] amt);
        countdown = ({1'b0, countdown} >= amt) ? countdown - amt[31:0] : '0;
    endtask

    task automatic predict_outcome(input request_t r);
        outcome_t    o;
        int unsigned c, n, i, cur, base;
        addr_t       head;
        o = '0;
        case (r.op)
            OP_ALLOC: begin
                c = class_of_bytes(r.size);
                if (c == 0) begin
                    o.status = ST_BAD_SIZE;
                end else begin
                    head = free_heads[c];
                    if (head == 0 && pages_out >= POOL_PAGES) begin
                        o.status = ST_POOL_EMPTY;
                    end else begin
                        if (head == 0) begin
                            base = pages_out * PAGE_WORDS + HEADER_WORDS;
                            n = (PAGE_WORDS - HEADER_WORDS) / c;
                            cur = base;
                            for (i = 0; i + 1 < n; i++) begin
                                block_link[addr_t'(cur)] = addr_t'(cur + c);
                                cur += c;
                            end
                            block_link[addr_t'(cur)] = '0;
                            head = addr_t'(base);
                            pages_out++;
                            drain_countdown(33'(PAGE_WORDS * WORD_BYTES));
                        end
                        o.addr = head;
                        free_heads[c] = block_link[head];
                        live_blocks.push_back('{head, c});
                    end
                end
            end
            OP_FREE: begin
                c = class_of_bytes(r.size);
                if (c == 0) begin
                    o.status = ST_BAD_SIZE;
                end else if (r.addr != 0) begin
                    block_link[r.addr] = free_heads[c];
                    free_heads[c] = r.addr;
                end
            end
            OP_REDUCE: drain_countdown({1'b0, r.amount});
            default: ;
        endcase
        o.due = (countdown == 0);
        o.pages = pages_out[6:0];
        outcomes_due.push_back(o);
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    task automatic queue_request(input opcode_t op, input int unsigned sz,
                                 input int unsigned ad, input count_t amt);
        request_t r;
        r.op = op;
        r.size = sz[15:0];
        r.addr = ad[ADDR_W-1:0];
        r.amount = amt;
        requests_to_send.push_back(r);
    endtask

    task automatic queue_mixed_burst(input int unsigned count);
        request_t    r;
        live_block_t b;
        int unsigned pick, idx, c, bad;
        repeat (count) begin
            r.op = OP_ALLOC;
            r.size = 16'($urandom_range(0, 65535));
            r.addr = ADDR_W'($urandom_range(0, ADDR_SPACE - 1));
            r.amount = $urandom();
            bad = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(MAX_SIZE + 1, 65535);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                r.size = 16'($urandom_range(1, MAX_SIZE));
            end else if (pick < 70 && live_blocks.size() != 0) begin
                idx = $urandom_range(0, live_blocks.size() - 1);
                b = live_blocks[idx];
                live_blocks.delete(idx);
                c = ($urandom_range(0, 9) == 0) ? $urandom_range(1, TOP_CLASS) : b.cls;
                r.op = OP_FREE;
                r.addr = b.addr;
                r.size = 16'((c - 1) * WORD_BYTES + $urandom_range(1, WORD_BYTES));
            end else if (pick < 78) begin
                r.op = OP_REDUCE;
                if ($urandom_range(0, 3) != 0) r.amount = $urandom_range(0, 8192);
            end else if (pick < 85) begin
                r.size = 16'(bad);
            end else if (pick < 92) begin
                r.op = OP_FREE;
                r.size = 16'(bad);
            end else if (pick < 96) begin
                r.op = OP_FREE;
                r.addr = '0;
                r.size = 16'($urandom_range(1, MAX_SIZE));
            end else begin
                r.op = OP_UNUSED;
            end
            requests_to_send.push_back(r);
        end
    endtask

    task automatic wait_until_sent();
        do @(negedge aclk); while (requests_to_send.size() != 0 || s_tvalid);
    endtask

    task automatic wait_until_idle();
        do @(negedge aclk);
        while (requests_to_send.size() != 0 || s_tvalid || outcomes_due.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_budget(input count_t v);
        wait_until_idle();
        @(posedge aclk);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        countdown = v;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) predict_outcome(in_flight);
            if (send_gap != 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (requests_to_send.size() != 0) begin
                in_flight = requests_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {1'b0, in_flight.amount, in_flight.addr, in_flight.size};
                s_tuser <= in_flight.op;
                send_gap = draw_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        outcome_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (outcomes_due.size() == 0) begin
                    report_mismatch("result transaction with no request outstanding");
                end else begin
                    want = outcomes_due.pop_front();
                    if (m_tdata[14:0] != want.addr)
                        report_mismatch($sformatf("result_addr got %0d expected %0d",
                                                  m_tdata[14:0], want.addr));
                    if (m_tuser != want.status)
                        report_mismatch($sformatf("status got %0d expected %0d",
                                                  m_tuser, want.status));
                    if (m_tdata[15] != want.due)
                        report_mismatch($sformatf("collect_due got %0b expected %0b",
                                                  m_tdata[15], want.due));
                    if (m_tdata[22:16] != want.pages)
                        report_mismatch($sformatf("pages_in_use got %0d expected %0d",
                                                  m_tdata[22:16], want.pages));
                end
                hold_cycles = draw_gap();
            end else if (m_tvalid && hold_cycles != 0) begin
                hold_cycles--;
            end
            m_tready <= (hold_cycles == 0);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        count_t      budgets [5];
        int unsigned burst, step, walk;
        addr_t       node;
        budgets = '{32'd0, 32'hFFFF_FFFF, 32'd3 * PAGE_WORDS * WORD_BYTES, 32'd1,
                    COUNTDOWN_RESET};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Carve first pages, then bad sizes, ignored frees, header reuse and countdown limits.
        queue_request(OP_ALLOC, 1, 0, 0);
        queue_request(OP_ALLOC, WORD_BYTES, ADDR_SPACE - 1, 32'hFFFF_FFFF);
        queue_request(OP_ALLOC, WORD_BYTES + 1, 0, 0);
        queue_request(OP_ALLOC, MAX_SIZE, 0, 0);
        queue_request(OP_ALLOC, 0, 0, 0);
        queue_request(OP_ALLOC, MAX_SIZE + 1, 0, 0);
        queue_request(OP_ALLOC, 65535, 0, 0);
        queue_request(OP_FREE, 0, ADDR_SPACE - 1, 0);
        queue_request(OP_FREE, 65535, ADDR_SPACE - 1, 0);
        queue_request(OP_FREE, WORD_BYTES, 0, 0);
        queue_request(OP_FREE, WORD_BYTES, (NUM_PAGES - 1) * PAGE_WORDS, 0);
        queue_request(OP_ALLOC, 3, 0, 0);
        queue_request(OP_REDUCE, 0, 0, 0);
        queue_request(OP_REDUCE, 0, 0, 32'hFFFF_FFFF);
        queue_request(OP_UNUSED, 65535, ADDR_SPACE - 1, 32'hFFFF_FFFF);
        queue_request(OP_ALLOC, 2 * WORD_BYTES, 0, 0);
        queue_request(OP_FREE, MAX_SIZE, PAGE_WORDS, 0);
        queue_request(OP_ALLOC, MAX_SIZE - WORD_BYTES + 1, 0, 0);
        wait_until_idle();

        for (burst = 0; burst < 10; burst++) begin
            if (burst % 2 == 0) write_budget(budgets[(burst / 2) % 5]);
            else write_budget($urandom());
            no_idle = ($urandom_range(0, 3) == 0);
            queue_mixed_burst(20);
            if (burst % 5 == 4) wait_until_idle();
            else wait_until_sent();
        end

        // Use up the pool through the widest class, then drain that list past empty.
        write_budget(budgets[2]);
        while (pages_out < POOL_PAGES) begin
            no_idle = ($urandom_range(0, 1) == 0);
            repeat (PAGE_WORDS / TOP_CLASS)
                queue_request(OP_ALLOC, MAX_SIZE, $urandom_range(0, ADDR_SPACE - 1), $urandom());
            wait_until_idle();
        end
        walk = 0;
        node = free_heads[TOP_CLASS];
        while (node != 0) begin
            walk++;
            node = block_link[node];
        end
        for (step = 0; step < walk + 3; step++)
            queue_request(OP_ALLOC, MAX_SIZE, 0, 0);
        wait_until_idle();

        for (burst = 0; burst < 3; burst++) begin
            no_idle = ($urandom_range(0, 3) == 0);
            queue_mixed_burst(20);
            wait_until_sent();
        end
        wait_until_idle();
        repeat (20) @(posedge aclk);

        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
hw/rtl/scba_pkg.sv
hw/rtl/scba_ram.sv
hw/rtl/size_class_block_allocator.sv
test/tb_size_class_block_allocator.sv
